// ===== rtl/core/websocket_frame_deframer_macros.svh =====
// assertion macros for the deframer checker
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, quiet during reset
`define WSD_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define WSD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/wsd_pkg.sv =====
// types, codes and helpers shared by the websocket deframer
`timescale 1ns / 1ps

package wsd_pkg;

   // parse phases
   localparam logic [2:0] PH_FIRST   = 3'd0;
   localparam logic [2:0] PH_SECOND  = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_DATA    = 3'd0;
   localparam logic [2:0] KIND_PING    = 3'd1;
   localparam logic [2:0] KIND_PONG    = 3'd2;
   localparam logic [2:0] KIND_CLOSE   = 3'd3;
   localparam logic [2:0] KIND_UNKNOWN = 3'd4;
   localparam logic [2:0] KIND_BADLEN  = 3'd5;

   // opcodes
   localparam logic [3:0] OP_BINARY = 4'd2;
   localparam logic [3:0] OP_CLOSE  = 4'd8;
   localparam logic [3:0] OP_PING   = 4'd9;
   localparam logic [3:0] OP_PONG   = 4'd10;

   // header length codes and byte counts
   localparam logic [6:0] LEN_EXT16   = 7'd126;
   localparam logic [6:0] LEN_EXT64   = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } wsd_beat_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [2:0] frame_kind;
      logic       frame_end;
      logic       msg_last;
   } wsd_result_type;

   typedef struct packed {
      logic           present;
      wsd_result_type res;
   } wsd_step_type;

   function automatic logic [2:0] wsd_kind_of(input logic [3:0] op);
      logic [2:0] kind;
      if (op <= OP_BINARY) kind = KIND_DATA;
      else if (op == OP_PING) kind = KIND_PING;
      else if (op == OP_PONG) kind = KIND_PONG;
      else if (op == OP_CLOSE) kind = KIND_CLOSE;
      else kind = KIND_UNKNOWN;
      return kind;
   endfunction

endpackage

// ===== rtl/core/wsd_req_if.sv =====
// stream byte channel into the deframer
`timescale 1ns / 1ps

interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/core/wsd_rsp_if.sv =====
// result word channel out of the deframer
`timescale 1ns / 1ps

interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic [2:0] frame_kind;
   logic       frame_end;
   logic       msg_last;

   modport source (output valid, output out_byte, output byte_valid, output frame_kind,
                   output frame_end, output msg_last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input frame_kind,
                   input frame_end, input msg_last, output ready);
endinterface

// ===== rtl/core/wsd_in_stage.sv =====
// input register for received stream bytes
`timescale 1ns / 1ps

module wsd_in_stage
   import wsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   wsd_req_if.sink      req_bus,
   input  logic         take,
   output wsd_beat_type beat
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       accept;

   assign req_bus.ready = !valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      if (accept) valid_in = 1'b1;
      else if (take) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_bus.in_byte;
      end
   end

   assign beat.valid = valid_ff;
   assign beat.data  = data_ff;

endmodule

// ===== rtl/core/wsd_parser.sv =====
// frame header parser, unmasking and result building
`timescale 1ns / 1ps

module wsd_parser
   import wsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  wsd_beat_type beat,
   output wsd_step_type step
);

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  hcount_ff, hcount_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff, fin_in;
   logic        mask_ff, mask_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  key_index_ff, key_index_in;
   logic        bad_ff, bad_in;

   logic        after_len, hdr_done;
   logic [63:0] len_val, rem_shift, rem_dec;
   logic [3:0]  hcount_dec;
   logic [2:0]  kind;
   logic [7:0]  key_byte, pay_byte;
   logic        last;

   always_comb begin
      unique case (key_index_ff)
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         2'd3: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      hcount_in    = hcount_ff;
      opcode_in    = opcode_ff;
      fin_in       = fin_ff;
      mask_in      = mask_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      key_index_in = key_index_ff;
      bad_in       = bad_ff;
      step         = '0;
      after_len    = 1'b0;
      hdr_done     = 1'b0;
      len_val      = remaining_ff;
      kind         = wsd_kind_of(opcode_ff);
      rem_shift    = {remaining_ff[55:0], beat.data};
      hcount_dec   = hcount_ff - 4'd1;
      rem_dec      = (remaining_ff != 64'd0) ? remaining_ff - 64'd1 : remaining_ff;
      last         = (rem_dec == 64'd0);
      pay_byte     = mask_ff ? (beat.data ^ key_byte) : beat.data;

      if (take && !bad_ff) begin
         unique case (phase_ff)
            PH_FIRST: begin
               fin_in    = beat.data[7];
               opcode_in = beat.data[3:0];
               phase_in  = PH_SECOND;
            end
            PH_SECOND: begin
               mask_in      = beat.data[7];
               remaining_in = 64'd0;
               if (!beat.data[7]) key_in = 32'd0;
               if (beat.data[6:0] == LEN_EXT16) begin
                  hcount_in = EXT16_BYTES;
                  phase_in  = PH_EXTLEN;
               end else if (beat.data[6:0] == LEN_EXT64) begin
                  hcount_in = EXT64_BYTES;
                  phase_in  = PH_EXTLEN;
               end else begin
                  remaining_in = {57'd0, beat.data[6:0]};
                  len_val      = {57'd0, beat.data[6:0]};
                  after_len    = 1'b1;
               end
            end
            PH_EXTLEN: begin
               remaining_in = rem_shift;
               hcount_in    = hcount_dec;
               len_val      = rem_shift;
               if (hcount_dec == 4'd0) begin
                  if (rem_shift[63]) begin
                     bad_in   = 1'b1;
                     phase_in = PH_FIRST;
                     step.present        = 1'b1;
                     step.res.frame_kind = KIND_BADLEN;
                     step.res.frame_end  = 1'b1;
                  end else begin
                     after_len = 1'b1;
                  end
               end
            end
            PH_KEY: begin
               key_in    = {key_ff[23:0], beat.data};
               hcount_in = hcount_dec;
               if (hcount_dec == 4'd0) hdr_done = 1'b1;
            end
            PH_PAYLOAD: begin
               key_index_in = key_index_ff + 2'd1;
               remaining_in = rem_dec;
               if (last) phase_in = PH_FIRST;
               if (kind == KIND_DATA || kind == KIND_PING) begin
                  step.present        = 1'b1;
                  step.res.out_byte   = pay_byte;
                  step.res.byte_valid = 1'b1;
                  step.res.frame_kind = kind;
                  step.res.frame_end  = last;
                  step.res.msg_last   = last && fin_ff && (kind == KIND_DATA);
               end else if (last) begin
                  step.present        = 1'b1;
                  step.res.frame_kind = kind;
                  step.res.frame_end  = 1'b1;
               end
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase
      end

      // length known: key bytes follow or the header is complete
      if (after_len) begin
         if (mask_in) begin
            phase_in  = PH_KEY;
            hcount_in = KEY_BYTES;
            key_in    = 32'd0;
         end else begin
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         key_index_in = 2'd0;
         if (len_val != 64'd0) begin
            phase_in = PH_PAYLOAD;
         end else begin
            phase_in = PH_FIRST;
            if (kind != KIND_DATA || fin_ff) begin
               step.present        = 1'b1;
               step.res.frame_kind = kind;
               step.res.frame_end  = 1'b1;
               step.res.msg_last   = (kind == KIND_DATA);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         hcount_ff    <= 4'd0;
         opcode_ff    <= 4'd0;
         fin_ff       <= 1'b0;
         mask_ff      <= 1'b0;
         remaining_ff <= 64'd0;
         key_ff       <= 32'd0;
         key_index_ff <= 2'd0;
         bad_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hcount_ff    <= hcount_in;
         opcode_ff    <= opcode_in;
         fin_ff       <= fin_in;
         mask_ff      <= mask_in;
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
         key_index_ff <= key_index_in;
         bad_ff       <= bad_in;
      end
   end

endmodule

// ===== rtl/core/wsd_out_stage.sv =====
// result register and flow control toward the result channel
`timescale 1ns / 1ps

module wsd_out_stage
   import wsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  wsd_beat_type beat,
   input  wsd_step_type step,
   output logic         take,
   wsd_rsp_if.source    rsp_bus
);

   logic           valid_ff, valid_in;
   wsd_result_type result_ff;

   // a pending byte moves on once the result slot is free or draining
   assign take = beat.valid && (!valid_ff || rsp_bus.ready);

   always_comb begin
      if (take) valid_in = step.present;
      else if (rsp_bus.ready) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && step.present) begin
         result_ff <= step.res;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.out_byte   = result_ff.out_byte;
   assign rsp_bus.byte_valid = result_ff.byte_valid;
   assign rsp_bus.frame_kind = result_ff.frame_kind;
   assign rsp_bus.frame_end  = result_ff.frame_end;
   assign rsp_bus.msg_last   = result_ff.msg_last;

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// top level of the websocket receive frame deframer
// data path: input register for the accepted byte, result register for its word
// throughput: one byte per cycle unless the result stalls, set by the combinational
//   parse step between both registers; a stalled result holds one byte behind it
// reset: synchronous active-high reset returns the parser to the first header byte,
//   clears the sticky bad-length flag and empties both registers
`timescale 1ns / 1ps

module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   wsd_req_if.sink   req_bus,
   wsd_rsp_if.source rsp_bus
);

   // byte held in the input register, and the step it produces
   wsd_beat_type beat;
   wsd_step_type step;
   // parse step fires when a byte is held and the result slot can take its word
   logic         take;

   // input register: ready whenever it is empty or its byte moves on this cycle
   wsd_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .take    (take),
      .beat    (beat)
   );

   // header parse, length count, key capture and payload unmasking;
   // header bytes and dropped control payload give no word, but for end and bad-length events
   wsd_parser u_parser (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .beat  (beat),
      .step  (step)
   );

   // result register drives the result channel and backpressures the parser
   wsd_out_stage u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .step    (step),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== rtl/core/wsd_checker.sv =====
// port-level checks of the deframer result channel, bound to the top level
`timescale 1ns / 1ps
`include "websocket_frame_deframer_macros.svh"

module wsd_checker
   import wsd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       byte_valid,
   input logic [2:0] frame_kind,
   input logic       frame_end,
   input logic       msg_last
);

   `WSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_byte) && $stable(frame_kind) && $stable(frame_end), "stalled result word changed")
   `WSD_ASSERT_NOW(a_event_ends_frame, clock, reset, rsp_valid && !byte_valid, frame_end && out_byte == 8'd0, "event word without frame end or with nonzero byte")
   `WSD_ASSERT_NOW(a_msg_end_data, clock, reset, rsp_valid && msg_last, frame_end && frame_kind == KIND_DATA, "message end outside a data frame end")
   `WSD_ASSERT_NOW(a_byte_kind, clock, reset, rsp_valid && byte_valid, frame_kind == KIND_DATA || frame_kind == KIND_PING, "payload byte from a dropped frame kind")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .out_byte   (rsp_bus.out_byte),
   .byte_valid (rsp_bus.byte_valid),
   .frame_kind (rsp_bus.frame_kind),
   .frame_end  (rsp_bus.frame_end),
   .msg_last   (rsp_bus.msg_last)
);

// ===== verif/tb_websocket_frame_deframer.sv =====
// self-checking testbench: directed and random frame streams through the deframer
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
   import wsd_pkg::*;

   // data opcodes that the package does not name
   localparam logic [3:0] OP_CONTINUATION = 4'd0;
   localparam logic [3:0] OP_TEXT         = 4'd1;

   // random stream length in input words, split over three idling plans
   localparam int unsigned RANDOM_BYTES = 1400;

   // result words that can be read straight off the frame layout
   localparam wsd_result_type NO_WORD       = '0;
   localparam wsd_result_type W_MSG_END     = '{8'h00, 1'b0, KIND_DATA,    1'b1, 1'b1};
   localparam wsd_result_type W_PING_END    = '{8'h00, 1'b0, KIND_PING,    1'b1, 1'b0};
   localparam wsd_result_type W_PONG_END    = '{8'h00, 1'b0, KIND_PONG,    1'b1, 1'b0};
   localparam wsd_result_type W_CLOSE_END   = '{8'h00, 1'b0, KIND_CLOSE,   1'b1, 1'b0};
   localparam wsd_result_type W_UNKNOWN_END = '{8'h00, 1'b0, KIND_UNKNOWN, 1'b1, 1'b0};
   localparam wsd_result_type W_BADLEN      = '{8'h00, 1'b0, KIND_BADLEN,  1'b1, 1'b0};

   // one directed input word; typed rows carry their own expected result word
   typedef struct packed {
      logic [7:0]     in_byte;
      logic           typed;
      wsd_result_type word;
   } stim_row_type;

   // rows before OPENING_ROWS run right after reset, the rest close the run
   // since a bad length locks the parser until reset
   localparam int OPENING_ROWS = 27;
   localparam stim_row_type DIRECTED_ROWS [43] = '{
      // empty text frame with fin: one empty message end
      '{8'h81, 1'b0, NO_WORD},
      '{8'h00, 1'b1, W_MSG_END},
      // empty ping
      '{8'h89, 1'b0, NO_WORD},
      '{8'h00, 1'b1, W_PING_END},
      // empty masked pong: event lands on the last key byte
      '{8'h8A, 1'b0, NO_WORD},
      '{8'h80, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      '{8'hA5, 1'b0, NO_WORD},
      '{8'h5A, 1'b1, W_PONG_END},
      // close without fin, one payload word dropped
      '{8'h08, 1'b0, NO_WORD},
      '{8'h01, 1'b0, NO_WORD},
      '{8'hFF, 1'b1, W_CLOSE_END},
      // unknown opcode with all rsv bits set
      '{8'hF3, 1'b0, NO_WORD},
      '{8'h00, 1'b1, W_UNKNOWN_END},
      // empty continuation without fin: nothing comes out
      '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      // masked binary, non-minimal 16-bit length of 2, all-ones key
      '{8'h82, 1'b0, NO_WORD},
      '{8'hFE, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      '{8'h02, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      // closing rows: 64-bit length with its top bit set
      '{8'h82, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, NO_WORD},
      '{8'h80, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD},
      '{8'h00, 1'b1, W_BADLEN},
      // stream is dead now: even an empty fin frame gives nothing
      '{8'h12, 1'b0, NO_WORD},
      '{8'h34, 1'b0, NO_WORD},
      '{8'h56, 1'b0, NO_WORD},
      '{8'h78, 1'b0, NO_WORD},
      '{8'h81, 1'b0, NO_WORD},
      '{8'h00, 1'b0, NO_WORD}
   };

   logic clock = 1'b0;
   logic reset;

   wsd_req_if req_bus ();
   wsd_rsp_if rsp_bus ();

   websocket_frame_deframer u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #10 clock = ~clock;

   // idling odds in percent per cycle
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   int unsigned error_count;
   int unsigned random_bytes;

   // result words still owed by the block, oldest first
   wsd_result_type expected_words[$];

   // parser copy kept by the testbench
   logic [2:0]  parse_state;
   logic [3:0]  hdr_left;
   logic [3:0]  cur_opcode;
   logic        cur_fin;
   logic        cur_masked;
   logic [63:0] bytes_left;
   logic [31:0] cur_key;
   logic [1:0]  key_pos;
   logic        sticky_bad;

   function automatic logic [2:0] kind_for(input logic [3:0] op);
      unique case (op)
         OP_CONTINUATION, OP_TEXT, OP_BINARY: return KIND_DATA;
         OP_PING:  return KIND_PING;
         OP_PONG:  return KIND_PONG;
         OP_CLOSE: return KIND_CLOSE;
         default:  return KIND_UNKNOWN;
      endcase
   endfunction

   // end of length field or of key: go fetch the key, open the payload, or end an empty frame
   task automatic close_header(input logic key_done, output logic produced,
                               output wsd_result_type word);
      logic [2:0] kind;
      kind = kind_for(cur_opcode);
      produced = 1'b0;
      word = NO_WORD;
      if (cur_masked && !key_done) begin
         parse_state = PH_KEY;
         hdr_left = KEY_BYTES;
         cur_key = '0;
      end else begin
         key_pos = '0;
         if (bytes_left != 0) begin
            parse_state = PH_PAYLOAD;
         end else begin
            // empty frame: non-data frames and fin data frames still report
            parse_state = PH_FIRST;
            if (kind != KIND_DATA) begin
               produced = 1'b1;
               word = '{8'h00, 1'b0, kind, 1'b1, 1'b0};
            end else if (cur_fin) begin
               produced = 1'b1;
               word = W_MSG_END;
            end
         end
      end
   endtask

   // advance the parser copy by one accepted word and give its result word
   task automatic deframe_byte(input logic [7:0] b, output logic produced,
                               output wsd_result_type word);
      logic [2:0] kind;
      logic [7:0] plain;
      logic       is_last;
      produced = 1'b0;
      word = NO_WORD;
      kind = kind_for(cur_opcode);
      if (!sticky_bad) begin
         unique case (parse_state)
            PH_FIRST: begin
               cur_fin = b[7];
               cur_opcode = b[3:0];
               parse_state = PH_SECOND;
            end
            PH_SECOND: begin
               cur_masked = b[7];
               bytes_left = '0;
               if (b[6:0] == LEN_EXT16) begin
                  hdr_left = EXT16_BYTES;
                  parse_state = PH_EXTLEN;
               end else if (b[6:0] == LEN_EXT64) begin
                  hdr_left = EXT64_BYTES;
                  parse_state = PH_EXTLEN;
               end else begin
                  bytes_left = 64'(b[6:0]);
                  close_header(1'b0, produced, word);
               end
            end
            PH_EXTLEN: begin
               // big-endian length, most significant word first
               bytes_left = {bytes_left[55:0], b};
               hdr_left = hdr_left - 4'd1;
               if (hdr_left == 0) begin
                  if (bytes_left[63]) begin
                     sticky_bad = 1'b1;
                     parse_state = PH_FIRST;
                     produced = 1'b1;
                     word = W_BADLEN;
                  end else begin
                     close_header(1'b0, produced, word);
                  end
               end
            end
            PH_KEY: begin
               cur_key = {cur_key[23:0], b};
               hdr_left = hdr_left - 4'd1;
               if (hdr_left == 0) close_header(1'b1, produced, word);
            end
            PH_PAYLOAD: begin
               plain = b;
               if (cur_masked) plain = b ^ cur_key[8 * (3 - key_pos) +: 8];
               key_pos = key_pos + 2'd1;
               if (bytes_left != 0) bytes_left = bytes_left - 64'd1;
               is_last = (bytes_left == 0);
               if (is_last) parse_state = PH_FIRST;
               if (kind == KIND_DATA) begin
                  produced = 1'b1;
                  word = '{plain, 1'b1, KIND_DATA, is_last, is_last & cur_fin};
               end else if (kind == KIND_PING) begin
                  produced = 1'b1;
                  word = '{plain, 1'b1, KIND_PING, is_last, 1'b0};
               end else if (is_last) begin
                  // pong, close and unknown only report the frame end
                  produced = 1'b1;
                  word = '{8'h00, 1'b0, kind, 1'b1, 1'b0};
               end
            end
            default: parse_state = PH_FIRST;
         endcase
      end
   endtask

   task automatic report_mismatch(input string what, input wsd_result_type got,
                                  input wsd_result_type want);
      error_count++;
      $display("%0t %s: got %02h/%0b/%0d/%0b/%0b want %02h/%0b/%0d/%0b/%0b", $time, what,
               got.out_byte, got.byte_valid, got.frame_kind, got.frame_end,
               got.msg_last, want.out_byte, want.byte_valid, want.frame_kind,
               want.frame_end, want.msg_last);
   endtask

   // offer one word, wait for the handshake, then predict what it causes
   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input wsd_result_type typed_word);
      logic           produced;
      wsd_result_type word;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      deframe_byte(b, produced, word);
      // typed rows stand on their own word, the parser copy still advances
      if (typed) expected_words.push_back(typed_word);
      else if (produced) expected_words.push_back(word);
   endtask

   task automatic send_octet(input logic [7:0] b);
      send_byte(b, 1'b0, NO_WORD);
      random_bytes++;
   endtask

   // one well-formed frame with random header fields, key and payload
   task automatic send_frame();
      logic [7:0]  head;
      logic        masked_f;
      logic [31:0] key_w;
      int unsigned len;
      int unsigned len_pick;
      int unsigned op_pick;
      head = 8'($urandom);
      // lean toward data and ping so payload words dominate
      op_pick = $urandom_range(99);
      if (op_pick < 60) head[3:0] = 4'($urandom_range(OP_BINARY));
      else if (op_pick < 72) head[3:0] = OP_PING;
      else if (op_pick < 80) head[3:0] = OP_PONG;
      else if (op_pick < 86) head[3:0] = OP_CLOSE;
      masked_f = 1'($urandom);
      key_w = $urandom;
      len_pick = $urandom_range(99);
      if (len_pick < 70) len = $urandom_range(8);
      else if (len_pick < 80) len = $urandom_range(125);
      else if ($urandom_range(9) == 0) len = $urandom_range(300);
      else len = $urandom_range(40);
      send_octet(head);
      if (len_pick < 80) begin
         send_octet({masked_f, 7'(len)});
      end else if (len_pick < 92) begin
         // 16-bit form, often non-minimal
         send_octet({masked_f, LEN_EXT16});
         send_octet(8'(len >> 8));
         send_octet(8'(len));
      end else begin
         // 64-bit form, top words zero so the length stays short
         send_octet({masked_f, LEN_EXT64});
         for (int i = 0; i < 8; i++) send_octet(8'(len >> (8 * (7 - i))));
      end
      if (masked_f)
         for (int i = 0; i < 4; i++) send_octet(key_w[8 * (3 - i) +: 8]);
      for (int unsigned i = 0; i < len; i++) send_octet(8'($urandom));
   endtask

   // sender holds off until every owed result word has come back
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   // result side: random back-pressure and the compare against the oldest word
   always @(posedge clock) begin : check_words
      wsd_result_type got;
      wsd_result_type want;
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.out_byte, rsp_bus.byte_valid, rsp_bus.frame_kind,
                 rsp_bus.frame_end, rsp_bus.msg_last};
         if (expected_words.size() == 0) begin
            report_mismatch("result word with nothing owed", got, NO_WORD);
         end else begin
            want = expected_words.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.frame_kind !== want.frame_kind || got.frame_end !== want.frame_end ||
                got.msg_last !== want.msg_last)
               report_mismatch("result word mismatch", got, want);
         end
      end
   end

   // run limit, far above the slowest legal run
   initial begin
      #20_000_000;
      $display("tb_websocket_frame_deframer failed");
      $finish;
   end

   initial begin
      error_count    = 0;
      random_bytes   = 0;
      send_idle_pct  = 24;
      recv_stall_pct = 52;
      parse_state    = PH_FIRST;
      hdr_left       = '0;
      cur_opcode     = '0;
      cur_fin        = 1'b0;
      cur_masked     = 1'b0;
      bytes_left     = '0;
      cur_key        = '0;
      key_pos        = '0;
      sticky_bad     = 1'b0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.in_byte <= 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed opening: empty data, ping, pong and unknown frames, a one-byte close, masking, extreme words
      for (int i = 0; i < OPENING_ROWS; i++)
         send_byte(DIRECTED_ROWS[i].in_byte, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].word);

      // random frames: sender light / receiver heavy, then swapped, then no idling
      while (random_bytes < RANDOM_BYTES / 3) send_frame();
      hold_until_drained();
      send_idle_pct  = 52;
      recv_stall_pct = 24;
      while (random_bytes < 2 * RANDOM_BYTES / 3) send_frame();
      hold_until_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (random_bytes < RANDOM_BYTES) send_frame();

      // bad length last, it locks the stream for good
      for (int i = OPENING_ROWS; i < $size(DIRECTED_ROWS); i++)
         send_byte(DIRECTED_ROWS[i].in_byte, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].word);

      hold_until_drained();
      // idle on to catch any stray result word
      repeat (8) @(posedge clock);
      if (error_count == 0) $display("tb_websocket_frame_deframer passed");
      else $display("tb_websocket_frame_deframer failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/wsd_pkg.sv
rtl/core/wsd_req_if.sv
rtl/core/wsd_rsp_if.sv
rtl/core/wsd_in_stage.sv
rtl/core/wsd_parser.sv
rtl/core/wsd_out_stage.sv
rtl/core/websocket_frame_deframer.sv
rtl/core/wsd_checker.sv
verif/tb_websocket_frame_deframer.sv
